// ----- rtl/bpc_pkg.sv -----
// bpc_pkg: shared types and constants for the barometric compensation pipeline
// used by bpc_front, bpc_div, bpc_back and the top level; depends on nothing

package bpc_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_COEFFS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_COEFFS_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_COEFFS_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_COEFFS_C = 3'd3;

   localparam logic signed [28:0] FINE_OFFSET = 29'sd128000;
   localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
   localparam logic [63:0]        PRESS_SCALE = 64'd3125;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

   // per-word control that rides along with the data
   typedef struct packed {
      logic               vld;
      logic signed [31:0] temp;
      logic               dz;
   } side_type;

endpackage

// ----- rtl/bpc_front.sv -----
// bpc_front: temperature path and pressure path up to the divider operands
// uses bpc_pkg types; ten register stages, all advanced by en

module bpc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_vld,
   input  logic [19:0]       raw_t,
   input  logic [19:0]       raw_p,
   input  bpc_pkg::coef_type coef,
   output bpc_pkg::side_type side,
   output logic [63:0]       dividend,
   output logic [63:0]       divisor
);

   logic [10:1] vld_ff;
   logic [19:0] rp_ff [1:8];

   logic signed [18:0] a_ff, a_in;
   logic signed [17:0] b_ff, b_in;
   logic signed [34:0] m1_ff, m1_in;
   logic signed [35:0] bb_ff, bb_in;
   logic signed [23:0] v1t_ff, v1t_in;
   logic signed [23:0] sq;
   logic signed [39:0] m2_ff, m2_in;
   logic signed [27:0] fine_ff, fine_in;
   logic signed [31:0] temp5_ff, temp5_in;
   logic signed [31:0] temp_ff [6:10];
   logic signed [28:0] pv_ff, pv_in;
   logic signed [57:0] sq2_ff, sq2_in;
   logic signed [44:0] mp5_ff, mp5_in, mp2_ff, mp2_in, mp5b_ff, mp2b_ff;
   logic signed [63:0] x6_ff, x6_in, x3_ff, x3_in;
   logic signed [63:0] v2_ff, v2_in, v1_ff, v1_in;
   logic [63:0]        d_ff, d_in, n_ff, n_in;
   logic [20:0]        pdiff;
   logic [63:0]        dvd_ff, dvd_in, dvs_ff, dvs_in;

   always_comb begin
      a_in = $signed({2'b0, raw_t[19:3]}) - $signed({2'b0, coef.t1, 1'b0});
      b_in = $signed({2'b0, raw_t[19:4]}) - $signed({2'b0, coef.t1});
      m1_in = a_ff * coef.t2;
      bb_in = b_ff * b_ff;
      v1t_in = 24'(m1_ff >>> 11);
      sq = 24'(bb_ff >>> 12);
      m2_in = sq * coef.t3;
      fine_in = 28'(v1t_ff) + 28'(m2_ff >>> 14);
      temp5_in = 32'((34'(fine_ff) * 34'sd5 + 34'sd128) >>> 8);
      pv_in = 29'(fine_ff) - bpc_pkg::FINE_OFFSET;
      sq2_in = pv_ff * pv_ff;
      mp5_in = pv_ff * coef.p5;
      mp2_in = pv_ff * coef.p2;
      // products kept modulo 2^64
      x6_in = sq2_ff * coef.p6;
      x3_in = sq2_ff * coef.p3;
      v2_in = x6_ff + (64'(mp5b_ff) << 17) + (64'(coef.p4) << 35);
      v1_in = (x3_ff >>> 8) + (64'(mp2b_ff) << 12);
      d_in = $unsigned(v1_ff + (64'sd1 <<< 47)) * {48'b0, coef.p1};
      pdiff = bpc_pkg::PRESS_FULL - {1'b0, rp_ff[8]};
      n_in = ({43'b0, pdiff} << 31) - $unsigned(v2_ff);
      dvs_in = $unsigned($signed(d_ff) >>> 33);
      dvd_in = n_ff * bpc_pkg::PRESS_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[9:1], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[1] <= raw_p;
         for (int i = 2; i <= 8; i++) begin
            rp_ff[i] <= rp_ff[i-1];
         end
         a_ff     <= a_in;
         b_ff     <= b_in;
         m1_ff    <= m1_in;
         bb_ff    <= bb_in;
         v1t_ff   <= v1t_in;
         m2_ff    <= m2_in;
         fine_ff  <= fine_in;
         temp5_ff <= temp5_in;
         pv_ff    <= pv_in;
         temp_ff[6] <= temp5_ff;
         for (int i = 7; i <= 10; i++) begin
            temp_ff[i] <= temp_ff[i-1];
         end
         sq2_ff  <= sq2_in;
         mp5_ff  <= mp5_in;
         mp2_ff  <= mp2_in;
         x6_ff   <= x6_in;
         x3_ff   <= x3_in;
         mp5b_ff <= mp5_ff;
         mp2b_ff <= mp2_ff;
         v2_ff   <= v2_in;
         v1_ff   <= v1_in;
         d_ff    <= d_in;
         n_ff    <= n_in;
         dvs_ff  <= dvs_in;
         dvd_ff  <= dvd_in;
      end
   end

   assign side.vld  = vld_ff[10];
   assign side.temp = temp_ff[10];
   assign side.dz   = 1'b0;
   assign dividend  = dvd_ff;
   assign divisor   = dvs_ff;

endmodule

// ----- rtl/bpc_div.sv -----
// bpc_div: pipelined signed 64-bit divide, truncating toward zero, one quotient bit a stage
// uses bpc_pkg::side_type; flags a zero divisor in the side word

module bpc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  bpc_pkg::side_type side_in,
   input  logic [63:0]       dividend,
   input  logic [63:0]       divisor,
   output bpc_pkg::side_type side_out,
   output logic [63:0]       quotient
);

   bpc_pkg::side_type side_ff [0:64];
   logic [63:0] rem_ff [0:64];
   logic [63:0] quo_ff [0:64];
   logic [63:0] mb_ff  [0:64];
   logic        neg_ff [0:64];
   bpc_pkg::side_type side_q_ff;
   logic [63:0] q_ff;

   // magnitudes and sign
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].vld <= 1'b0;
      end else if (en) begin
         side_ff[0].vld <= side_in.vld;
      end
      if (en) begin
         side_ff[0].temp <= side_in.temp;
         side_ff[0].dz   <= (divisor == 64'd0);
         rem_ff[0] <= '0;
         quo_ff[0] <= dividend[63] ? (64'd0 - dividend) : dividend;
         mb_ff[0]  <= divisor[63] ? (64'd0 - divisor) : divisor;
         neg_ff[0] <= dividend[63] ^ divisor[63];
      end
   end

   for (genvar i = 0; i < 64; i++) begin : g_step
      logic [64:0] r;
      logic [64:0] t;

      always_comb begin
         r = {rem_ff[i], quo_ff[i][63]};
         t = r - {1'b0, mb_ff[i]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i+1].vld <= 1'b0;
         end else if (en) begin
            side_ff[i+1].vld <= side_ff[i].vld;
         end
         if (en) begin
            side_ff[i+1].temp <= side_ff[i].temp;
            side_ff[i+1].dz   <= side_ff[i].dz;
            rem_ff[i+1] <= t[64] ? r[63:0] : t[63:0];
            quo_ff[i+1] <= {quo_ff[i][62:0], ~t[64]};
            mb_ff[i+1]  <= mb_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_q_ff.vld <= 1'b0;
      end else if (en) begin
         side_q_ff.vld <= side_ff[64].vld;
      end
      if (en) begin
         side_q_ff.temp <= side_ff[64].temp;
         side_q_ff.dz   <= side_ff[64].dz;
         q_ff <= neg_ff[64] ? (64'd0 - quo_ff[64]) : quo_ff[64];
      end
   end

   assign side_out = side_q_ff;
   assign quotient = q_ff;

endmodule

// ----- rtl/bpc_back.sv -----
// bpc_back: pressure correction terms after the divide and the result register
// uses bpc_pkg types; four register stages, the last one drives the result ports

module bpc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  bpc_pkg::side_type side_in,
   input  logic [63:0]       quotient,
   input  bpc_pkg::coef_type coef,
   output logic              out_vld,
   output logic signed [31:0] out_temp,
   output logic [31:0]       out_press,
   output logic              out_dz
);

   bpc_pkg::side_type side_ff [1:3];
   logic [63:0]        p_ff [1:3];
   logic [63:0]        qv;
   logic [63:0]        ll_ff, ll_in;
   logic [31:0]        hl_ff, hl_in;
   logic signed [63:0] w2m_ff [1:3];
   logic signed [63:0] w2m_in;
   logic [63:0]        qq_ff, qq_in;
   logic signed [63:0] x9_ff, x9_in;
   logic signed [63:0] sum;
   logic signed [63:0] res;
   logic               vld_ff;
   logic signed [31:0] temp_ff;
   logic [31:0]        press_ff, press_in;
   logic               dz_ff;

   always_comb begin
      qv = $unsigned($signed(quotient) >>> 13);
      ll_in = 64'(qv[31:0]) * 64'(qv[31:0]);
      hl_in = 32'(qv[63:32] * qv[31:0]);
      w2m_in = $signed(quotient) * coef.p8;
      // square modulo 2^64 from 32-bit halves
      qq_in = ll_ff + (64'(hl_ff) << 33);
      x9_in = $signed(qq_ff) * coef.p9;
      sum = $signed(p_ff[3]) + (x9_ff >>> 25) + (w2m_ff[3] >>> 19);
      res = (sum >>> 8) + (64'(coef.p7) << 4);
      press_in = side_ff[3].dz ? 32'd0 : res[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[1].vld <= 1'b0;
         side_ff[2].vld <= 1'b0;
         side_ff[3].vld <= 1'b0;
         vld_ff <= 1'b0;
      end else if (en) begin
         side_ff[1].vld <= side_in.vld;
         side_ff[2].vld <= side_ff[1].vld;
         side_ff[3].vld <= side_ff[2].vld;
         vld_ff <= side_ff[3].vld;
      end
      if (en) begin
         side_ff[1].temp <= side_in.temp;
         side_ff[1].dz   <= side_in.dz;
         side_ff[2].temp <= side_ff[1].temp;
         side_ff[2].dz   <= side_ff[1].dz;
         side_ff[3].temp <= side_ff[2].temp;
         side_ff[3].dz   <= side_ff[2].dz;
         p_ff[1] <= quotient;
         p_ff[2] <= p_ff[1];
         p_ff[3] <= p_ff[2];
         w2m_ff[1] <= w2m_in;
         w2m_ff[2] <= w2m_ff[1];
         w2m_ff[3] <= w2m_ff[2];
         ll_ff <= ll_in;
         hl_ff <= hl_in;
         qq_ff <= qq_in;
         x9_ff <= x9_in;
         temp_ff  <= side_ff[3].temp;
         dz_ff    <= side_ff[3].dz;
         press_ff <= press_in;
      end
   end

   assign out_vld   = vld_ff;
   assign out_temp  = temp_ff;
   assign out_press = press_ff;
   assign out_dz    = dz_ff;

endmodule

// ----- rtl/barometric_temp_pressure_compensation.sv -----
// channel | direction | fields
// req     | in        | raw_temperature[19:0], raw_pressure[19:0]
// rsp     | out       | temperature_centideg[31:0], pressure_q24_8[31:0], divisor_zero
// csr     | in        | csr_index[2:0], csr_wdata[47:0] on csr_we
//
// one word enters per cycle while req_stall is low; the pipe holds ten front
// stages, 66 in the divider (sign, one quotient bit per stage, sign fix) and four back stages
// the divider's 64 quotient-bit stages set the depth; the whole pipe advances together
// reset clears the valid bits and the four coefficient registers
// a stalled result holds the pipe, so req_stall follows rsp_stall while a word waits
// depends on bpc_pkg, bpc_front, bpc_div, bpc_back

module barometric_temp_pressure_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_temperature_centideg,
   output logic [31:0]        rsp_pressure_q24_8,
   output logic               rsp_divisor_zero,
   input  logic               csr_we,
   input  logic [bpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpc_pkg::CSR_DAT_W-1:0] csr_wdata
);

   logic [47:0] temp_coeffs_ff, press_a_ff, press_b_ff, press_c_ff;
   bpc_pkg::coef_type coef;
   bpc_pkg::side_type front_side, div_side;
   logic [63:0] dividend, divisor, quotient;
   logic        en;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bpc_pkg::CSR_TEMP_COEFFS:    temp_coeffs_ff <= csr_wdata;
            bpc_pkg::CSR_PRESS_COEFFS_A: press_a_ff     <= csr_wdata;
            bpc_pkg::CSR_PRESS_COEFFS_B: press_b_ff     <= csr_wdata;
            bpc_pkg::CSR_PRESS_COEFFS_C: press_c_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.t1 = temp_coeffs_ff[15:0];
      coef.t2 = temp_coeffs_ff[31:16];
      coef.t3 = temp_coeffs_ff[47:32];
      coef.p1 = press_a_ff[15:0];
      coef.p2 = press_a_ff[31:16];
      coef.p3 = press_a_ff[47:32];
      coef.p4 = press_b_ff[15:0];
      coef.p5 = press_b_ff[31:16];
      coef.p6 = press_b_ff[47:32];
      coef.p7 = press_c_ff[15:0];
      coef.p8 = press_c_ff[31:16];
      coef.p9 = press_c_ff[47:32];
   end

   // pipe moves unless a finished word is held
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   bpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .raw_t    (req_raw_temperature),
      .raw_p    (req_raw_pressure),
      .coef     (coef),
      .side     (front_side),
      .dividend (dividend),
      .divisor  (divisor)
   );

   bpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .side_in  (front_side),
      .dividend (dividend),
      .divisor  (divisor),
      .side_out (div_side),
      .quotient (quotient)
   );

   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .side_in   (div_side),
      .quotient  (quotient),
      .coef      (coef),
      .out_vld   (rsp_valid),
      .out_temp  (rsp_temperature_centideg),
      .out_press (rsp_pressure_q24_8),
      .out_dz    (rsp_divisor_zero)
   );

endmodule

// ----- bench/testbench.sv -----
// testbench for barometric_temp_pressure_compensation: a queue-fed driver and a
// checking monitor around an in-bench compensation predictor
// depends on bpc_pkg and the rtl of the block
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [19:0] raw_t;
      logic [19:0] raw_p;
   } sample_type;

   typedef struct packed {
      logic signed [31:0] temp;
      logic [31:0]        press;
      logic               dz;
   } comp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [19:0]        req_raw_temperature;
   logic [19:0]        req_raw_pressure;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_temperature_centideg;
   logic [31:0]        rsp_pressure_q24_8;
   logic               rsp_divisor_zero;
   logic               csr_we;
   logic [bpc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bpc_pkg::CSR_DAT_W-1:0] csr_wdata;

   sample_type pending_samples[$];
   comp_type   expected_comp[$];
   logic [47:0] coef_regs[4];
   int send_idle, recv_idle;
   int errors, queued_count, checked_count, quiet_cycles;

   barometric_temp_pressure_compensation dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bench copy of the integer compensation
   function automatic comp_type compensate(logic [19:0] rt_in, logic [19:0] rp_in);
      comp_type r;
      longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint a, b, v1, v2, fine, tc, p, w1, w2, num;
      rt = longint'({44'b0, rt_in});
      rp = longint'({44'b0, rp_in});
      t1 = longint'({48'b0, coef_regs[0][15:0]});
      t2 = longint'($signed(coef_regs[0][31:16]));
      t3 = longint'($signed(coef_regs[0][47:32]));
      p1 = longint'({48'b0, coef_regs[1][15:0]});
      p2 = longint'($signed(coef_regs[1][31:16]));
      p3 = longint'($signed(coef_regs[1][47:32]));
      p4 = longint'($signed(coef_regs[2][15:0]));
      p5 = longint'($signed(coef_regs[2][31:16]));
      p6 = longint'($signed(coef_regs[2][47:32]));
      p7 = longint'($signed(coef_regs[3][15:0]));
      p8 = longint'($signed(coef_regs[3][31:16]));
      p9 = longint'($signed(coef_regs[3][47:32]));
      a = (rt >>> 3) - (t1 <<< 1);
      v1 = (a * t2) >>> 11;
      b = (rt >>> 4) - t1;
      v2 = (((b * b) >>> 12) * t3) >>> 14;
      fine = v1 + v2;
      tc = (fine * 5 + 128) >>> 8;
      v1 = fine - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.temp = tc[31:0];
      r.press = '0;
      r.dz = 1'b0;
      if (v1 == 0) begin
         r.dz = 1'b1;
      end else begin
         p = 64'sd1048576 - rp;
         num = ((p <<< 31) - v2) * 64'sd3125;
         // minus one divisor wraps the most negative value onto itself
         if (v1 == -64'sd1) begin
            p = -num;
         end else begin
            p = num / v1;
         end
         w1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
         w2 = (p8 * p) >>> 19;
         p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
         r.press = p[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_raw_temperature <= '0;
         req_raw_pressure <= '0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_comp.push_back(compensate(req_raw_temperature, req_raw_pressure));
         end
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
            sample_type s;
            s = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_raw_temperature <= s.raw_t;
            req_raw_pressure <= s.raw_p;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_comp.size() == 0) begin
               $display("result word with nothing expected");
               errors++;
            end else begin
               comp_type e;
               e = expected_comp.pop_front();
               if (rsp_temperature_centideg !== e.temp)
                  report_mismatch("temperature", longint'(rsp_temperature_centideg),
                                  longint'(e.temp));
               if (rsp_pressure_q24_8 !== e.press)
                  report_mismatch("pressure", longint'(rsp_pressure_q24_8),
                                  longint'(e.press));
               if (rsp_divisor_zero !== e.dz)
                  report_mismatch("divisor_zero", longint'(rsp_divisor_zero),
                                  longint'(e.dz));
            end
            checked_count++;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 20000) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [bpc_pkg::CSR_IDX_W-1:0] idx, logic [47:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx <= bpc_pkg::CSR_PRESS_COEFFS_C) coef_regs[idx[1:0]] = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_sample(logic [19:0] rt, logic [19:0] rp);
      sample_type s;
      s.raw_t = rt;
      s.raw_p = rp;
      pending_samples.push_back(s);
      queued_count++;
   endtask

   task automatic drain();
      while (checked_count != queued_count) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic directed_samples();
      push_sample(20'h00000, 20'h00000);
      push_sample(20'hfffff, 20'hfffff);
      push_sample(20'h00000, 20'hfffff);
      push_sample(20'hfffff, 20'h00000);
      push_sample(20'd519888, 20'd415148);
      push_sample(20'h80000, 20'h7ffff);
   endtask

   task automatic random_samples(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) == 0)
            push_sample(20'($urandom_range(20'hfffff)), 20'($urandom_range(20'hfffff)));
         else
            push_sample(20'($urandom_range(560000, 480000)),
                        20'($urandom_range(460000, 250000)));
      end
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(16'hffff)), $urandom};
   endfunction

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle = 0;
      recv_idle = 0;
      errors = 0;
      queued_count = 0;
      checked_count = 0;
      quiet_cycles = 0;
      for (int i = 0; i < 4; i++) coef_regs[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients give a zero divisor
      directed_samples();
      drain();

      // typical sensor calibration
      csr_write(bpc_pkg::CSR_TEMP_COEFFS, {16'hfc18, 16'd26435, 16'd27504});
      csr_write(bpc_pkg::CSR_PRESS_COEFFS_A, {16'd3024, 16'hd643, 16'd36477});
      csr_write(bpc_pkg::CSR_PRESS_COEFFS_B, {16'hfff9, 16'd140, 16'd2855});
      csr_write(bpc_pkg::CSR_PRESS_COEFFS_C, {16'd6000, 16'hc6f8, 16'd15500});
      // writes to indexes past the last register are dropped
      csr_write(bpc_pkg::CSR_IDX_W'($urandom_range(7, 4)), rand48());
      csr_write(bpc_pkg::CSR_IDX_W'($urandom_range(7, 4)), rand48());
      directed_samples();
      drain();

      // all ones, then the most negative signed value in every 16-bit field
      for (int r = 0; r < 4; r++) csr_write(r[bpc_pkg::CSR_IDX_W-1:0], 48'hffffffffffff);
      directed_samples();
      drain();
      for (int r = 0; r < 4; r++) csr_write(r[bpc_pkg::CSR_IDX_W-1:0], 48'h800080008000);
      directed_samples();
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph < 2) ? 32 : (ph < 4) ? 53 : 0;
         recv_idle = (ph < 2) ? 53 : (ph < 4) ? 32 : 0;
         if (ph % 2 == 0) begin
            csr_write(bpc_pkg::CSR_TEMP_COEFFS, {16'hfc18, 16'd26435, 16'd27504});
            csr_write(bpc_pkg::CSR_PRESS_COEFFS_A, {16'd3024, 16'hd643, 16'd36477});
            csr_write(bpc_pkg::CSR_PRESS_COEFFS_B, {16'hfff9, 16'd140, 16'd2855});
            csr_write(bpc_pkg::CSR_PRESS_COEFFS_C, {16'd6000, 16'hc6f8, 16'd15500});
         end else begin
            for (int r = 0; r < 4; r++) csr_write(r[bpc_pkg::CSR_IDX_W-1:0], rand48());
            csr_write(bpc_pkg::CSR_IDX_W'($urandom_range(7, 4)), rand48());
         end
         random_samples(225);
         drain();
      end

      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/bpc_pkg.sv
rtl/bpc_front.sv
rtl/bpc_div.sv
rtl/bpc_back.sv
rtl/barometric_temp_pressure_compensation.sv
bench/testbench.sv
